/* rtl/sync_sweep_pulse_decoder_macros.svh */
// ----------------------------------------------------------------------------
// Sync sweep pulse decoder assertion macros
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_SWEEP_PULSE_DECODER_MACROS_SVH
`define SYNC_SWEEP_PULSE_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssp assertion failed");

`endif

/* rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// Sync sweep pulse decoder package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

   localparam int TIME_W = 16;
   localparam int TICK_W = 7;
   localparam int US_W   = 22;
   localparam int KIND_W = 2;
   localparam int IDX_W  = 3;

   localparam logic [US_W-1:0]   US_MAX = {US_W{1'b1}};

   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SYNC  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd2;

   typedef enum logic [IDX_W-1:0] {
      CSR_SYNC_MIN    = 3'd0,
      CSR_SYNC_LIMIT  = 3'd1,
      CSR_SWEEP_FLOOR = 3'd2,
      CSR_SWEEP_LIMIT = 3'd3,
      CSR_US_PER_TICK = 3'd4
   } ssp_csr_index_type;

   localparam logic [TIME_W-1:0] RST_SYNC_MIN    = 16'd12;
   localparam logic [TIME_W-1:0] RST_SYNC_LIMIT  = 16'd68;
   localparam logic [TIME_W-1:0] RST_SWEEP_FLOOR = 16'd2;
   localparam logic [TIME_W-1:0] RST_SWEEP_LIMIT = 16'd6;
   localparam logic [TICK_W-1:0] RST_US_PER_TICK = 7'd8;

   typedef struct packed {
      logic [TIME_W-1:0] sync_width_min;
      logic [TIME_W-1:0] sync_width_limit;
      logic [TIME_W-1:0] sweep_width_floor;
      logic [TIME_W-1:0] sweep_width_limit;
      logic [TICK_W-1:0] us_per_tick;
   } ssp_cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] rise_time;
      logic [TIME_W-1:0] width_ticks;
      logic              is_sync;
      logic              is_sweep;
   } ssp_entry_type;

endpackage

`default_nettype wire

/* rtl/ssp_csr.sv */
// ----------------------------------------------------------------------------
// Sync sweep pulse decoder configuration registers
// Holds the width windows and the tick conversion factor.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_csr
   import ssp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [TIME_W-1:0] csr_wdata,
   output ssp_cfg_type            cfg
);

   ssp_cfg_type cfg_ff;
   ssp_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (ssp_csr_index_type'(csr_index))
            CSR_SYNC_MIN:    cfg_in.sync_width_min    = csr_wdata;
            CSR_SYNC_LIMIT:  cfg_in.sync_width_limit  = csr_wdata;
            CSR_SWEEP_FLOOR: cfg_in.sweep_width_floor = csr_wdata;
            CSR_SWEEP_LIMIT: cfg_in.sweep_width_limit = csr_wdata;
            CSR_US_PER_TICK: cfg_in.us_per_tick       = csr_wdata[TICK_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_width_min    <= RST_SYNC_MIN;
         cfg_ff.sync_width_limit  <= RST_SYNC_LIMIT;
         cfg_ff.sweep_width_floor <= RST_SWEEP_FLOOR;
         cfg_ff.sweep_width_limit <= RST_SWEEP_LIMIT;
         cfg_ff.us_per_tick       <= RST_US_PER_TICK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ssp_front.sv */
// ----------------------------------------------------------------------------
// Sync sweep pulse decoder front end
// Takes a pulse, measures its width and classifies it against the windows.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_front
   import ssp_pkg::*;
(
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [TIME_W-1:0] rise_time,
   input  wire logic [TIME_W-1:0] fall_time,
   input  wire ssp_cfg_type       cfg,
   output logic                   push,
   output ssp_entry_type          entry,
   input  wire logic              queue_full
);

   logic [TIME_W-1:0] width;

   assign width     = fall_time - rise_time;
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      entry.rise_time   = rise_time;
      entry.width_ticks = width;
      entry.is_sync     = (width >= cfg.sync_width_min) && (width < cfg.sync_width_limit);
      entry.is_sweep    = (width > cfg.sweep_width_floor) && (width < cfg.sweep_width_limit);
   end

endmodule

`default_nettype wire

/* rtl/ssp_queue.sv */
// ----------------------------------------------------------------------------
// Sync sweep pulse decoder queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_queue #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/ssp_back.sv */
// ----------------------------------------------------------------------------
// Sync sweep pulse decoder back end
// Runs the sync counter and arming, converts delays and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_sweep_pulse_decoder_macros.svh"

module ssp_back
   import ssp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   entry_valid,
   input  wire ssp_entry_type          entry,
   output logic                        pop,
   input  wire logic [TICK_W-1:0]      us_per_tick,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [KIND_W-1:0]           pulse_kind,
   output logic [TIME_W-1:0]           width_ticks,
   output logic [US_W-1:0]             x_time_us,
   output logic [US_W-1:0]             y_time_us,
   output logic                        x_updated,
   output logic                        y_updated
);

   localparam int PROD_W = TIME_W + TICK_W;

   logic [2:0]          sync_count_ff, sync_count_in;
   logic                x_armed_ff, x_armed_in;
   logic                y_armed_ff, y_armed_in;
   logic [TIME_W-1:0]   sync_time_ff, sync_time_in;
   logic [US_W-1:0]     x_delay_ff, x_delay_in;
   logic [US_W-1:0]     y_delay_ff, y_delay_in;
   logic                rsp_valid_ff;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [TIME_W-1:0]   width_ff;
   logic                x_upd_ff, x_upd_in;
   logic                y_upd_ff, y_upd_in;
   logic [2:0]          count_inc;
   logic [TIME_W-1:0]   ticks;
   logic [PROD_W-1:0]   product;
   logic [US_W-1:0]     delay_us;

   assign pop = entry_valid && (!rsp_valid_ff || rsp_ready);

   // A pulse that is both sync and sweep measures from its own rise.
   assign ticks    = entry.is_sync ? '0 : (entry.rise_time - sync_time_ff);
   assign product  = PROD_W'(ticks) * PROD_W'(us_per_tick);
   assign delay_us = (product > PROD_W'(US_MAX)) ? US_MAX : product[US_W-1:0];
   assign count_inc = sync_count_ff + 3'd1;

   always_comb begin
      sync_count_in = sync_count_ff;
      x_armed_in    = x_armed_ff;
      y_armed_in    = y_armed_ff;
      sync_time_in  = sync_time_ff;
      x_delay_in    = x_delay_ff;
      y_delay_in    = y_delay_ff;
      kind_in       = KIND_OTHER;
      x_upd_in      = 1'b0;
      y_upd_in      = 1'b0;
      if (entry.is_sync) begin
         kind_in       = KIND_SYNC;
         sync_count_in = count_inc;
         sync_time_in  = entry.rise_time;
         if (count_inc > 3'd1) begin
            y_armed_in = 1'b0;
         end
         if (count_inc == 3'd3) begin
            x_armed_in = 1'b1;
         end
         if (count_inc == 3'd4) begin
            sync_count_in = '0;
            x_armed_in    = 1'b0;
         end
      end
      if (entry.is_sweep) begin
         if (!entry.is_sync) begin
            kind_in = KIND_SWEEP;
         end
         sync_count_in = '0;
         if (y_armed_in) begin
            y_delay_in = delay_us;
            y_upd_in   = 1'b1;
            y_armed_in = 1'b0;
         end
         if (x_armed_in) begin
            x_delay_in = delay_us;
            x_upd_in   = 1'b1;
            y_armed_in = 1'b1;
            x_armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_count_ff <= '0;
         x_armed_ff    <= 1'b0;
         y_armed_ff    <= 1'b0;
         sync_time_ff  <= '0;
         x_delay_ff    <= '0;
         y_delay_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            sync_count_ff <= sync_count_in;
            x_armed_ff    <= x_armed_in;
            y_armed_ff    <= y_armed_in;
            sync_time_ff  <= sync_time_in;
            x_delay_ff    <= x_delay_in;
            y_delay_ff    <= y_delay_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= kind_in;
         width_ff <= entry.width_ticks;
         x_upd_ff <= x_upd_in;
         y_upd_ff <= y_upd_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign pulse_kind  = kind_ff;
   assign width_ticks = width_ff;
   assign x_time_us   = x_delay_ff;
   assign y_time_us   = y_delay_ff;
   assign x_updated   = x_upd_ff;
   assign y_updated   = y_upd_ff;

   `SSP_ASSERT_NOW(a_arm_exclusive, x_armed_ff, !y_armed_ff)
   `SSP_ASSERT_NOW(a_x_armed_count, x_armed_ff, sync_count_ff == 3'd3)
   `SSP_ASSERT_NEXT(a_pop_loads_rsp, pop, rsp_valid_ff)
   `SSP_ASSERT_NEXT(a_x_upd_arms_y, pop && x_upd_in, y_armed_ff && !x_armed_ff)

endmodule

`default_nettype wire

/* rtl/sync_sweep_pulse_decoder.sv */
// ----------------------------------------------------------------------------
// Sync sweep pulse decoder
// Classifies optical pulses by width and times sweeps against sync pulses.
//
//   Channel  Direction  Payload
//   req_     in         tdata: rise_time, fall_time
//   rsp_     out        tuser: pulse_kind; tdata: width, x/y times, update flags
//   csr_     in         index and write data, always ready
//
// One item per cycle is sustained while rsp_tready is high; the back end
// updates all state in one step. An item is registered in the queue, then in
// the back end, before its result reaches rsp_. Synchronous reset restores
// the register defaults and clears the queue and the sync and arming state.
// The queue holds QUEUE_DEPTH items; req_tready drops only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_sweep_pulse_decoder
   import ssp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // [15:0] rise_time, [31:16] fall_time
   input  wire logic [31:0]       req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // [15:0] width_ticks, [37:16] x_time_us, [59:38] y_time_us,
   // [60] x_updated, [61] y_updated, [63:62] zero
   output logic [63:0]            rsp_tdata,
   // [1:0] pulse_kind
   output logic [KIND_W-1:0]      rsp_tuser,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [TIME_W-1:0] csr_wdata
);

   localparam int ENTRY_W = $bits(ssp_entry_type);

   ssp_cfg_type       cfg;
   ssp_entry_type     entry_push;
   ssp_entry_type     entry_head;
   logic [ENTRY_W-1:0] head_bits;
   logic              push, pop, queue_full, queue_valid;
   logic [TIME_W-1:0] width_ticks;
   logic [US_W-1:0]   x_time_us, y_time_us;
   logic              x_updated, y_updated;

   ssp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssp_front u_front (
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .rise_time  (req_tdata[15:0]),
      .fall_time  (req_tdata[31:16]),
      .cfg        (cfg),
      .push       (push),
      .entry      (entry_push),
      .queue_full (queue_full)
   );

   ssp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry_push),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_valid),
      .head      (head_bits)
   );

   assign entry_head = ssp_entry_type'(head_bits);

   ssp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_valid),
      .entry       (entry_head),
      .pop         (pop),
      .us_per_tick (cfg.us_per_tick),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .pulse_kind  (rsp_tuser),
      .width_ticks (width_ticks),
      .x_time_us   (x_time_us),
      .y_time_us   (y_time_us),
      .x_updated   (x_updated),
      .y_updated   (y_updated)
   );

   assign rsp_tdata = {2'b00, y_updated, x_updated, y_time_us, x_time_us, width_ticks};

endmodule

`default_nettype wire
